// File: sv/rf2d_pkg.sv
// package for the two-pass recursive image filter
// holds register codes, reset values and the controller/datapath command types
// no dependencies
`default_nettype none

package rf2d_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int DIM_W  = 11;
  localparam int COEF_W = 16;
  localparam int SMP_W  = 16;
  localparam int VAL_W  = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FF     = 2'd2;
  localparam logic [1:0] REG_FB     = 2'd3;

  localparam logic [DIM_W-1:0]         WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]         HEIGHT_RST = 11'd1024;
  localparam logic signed [COEF_W-1:0] FF_RST     = 16'sd16384;
  localparam logic signed [COEF_W-1:0] FB_RST     = 16'sd0;

  typedef struct packed {
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic signed [COEF_W-1:0] ff;
    logic signed [COEF_W-1:0] fb;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic sum1;
    logic mul2;
    logic sum2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// File: sv/rf2d_cfg.sv
// configuration register file with apb-style access
// depends on rf2d_pkg
`default_nettype none

module rf2d_cfg (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [rf2d_pkg::ADDR_W-1:0]    paddr,
  input  wire  [rf2d_pkg::DATA_W-1:0]    pwdata,
  output logic [rf2d_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output rf2d_pkg::cfg_t                 cfg
);

  rf2d_pkg::cfg_t cfg_r, cfg_nxt;
  logic           wr_en;
  logic [1:0]     reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        rf2d_pkg::REG_WIDTH:  cfg_nxt.width  = pwdata[rf2d_pkg::DIM_W-1:0];
        rf2d_pkg::REG_HEIGHT: cfg_nxt.height = pwdata[rf2d_pkg::DIM_W-1:0];
        rf2d_pkg::REG_FF:     cfg_nxt.ff     = pwdata[rf2d_pkg::COEF_W-1:0];
        rf2d_pkg::REG_FB:     cfg_nxt.fb     = pwdata[rf2d_pkg::COEF_W-1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= rf2d_pkg::WIDTH_RST;
      cfg_r.height <= rf2d_pkg::HEIGHT_RST;
      cfg_r.ff     <= rf2d_pkg::FF_RST;
      cfg_r.fb     <= rf2d_pkg::FB_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      rf2d_pkg::REG_WIDTH:  prdata = {21'd0, cfg_r.width};
      rf2d_pkg::REG_HEIGHT: prdata = {21'd0, cfg_r.height};
      rf2d_pkg::REG_FF:     prdata = {{16{cfg_r.ff[15]}}, cfg_r.ff};
      rf2d_pkg::REG_FB:     prdata = {{16{cfg_r.fb[15]}}, cfg_r.fb};
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: sv/rf2d_ctrl.sv
// sequencing state machine: accept, two multiply/sum pairs, output hand-off
// depends on rf2d_pkg
`default_nettype none

module rf2d_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  rf2d_pkg::status_t   status,
  output rf2d_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL1 = 3'd1;
  localparam logic [2:0] S_SUM1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_SUM2 = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_SUM1;
      end
      S_SUM1: begin
        cmd.sum1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_SUM2;
      end
      S_SUM2: begin
        cmd.sum2  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/rf2d_dp.sv
// datapath: position counters, line store, q2.14 multiplies, rounding, clipping
// and the output register; depends on rf2d_pkg
`default_nettype none

module rf2d_dp #(
  parameter int MAX_WIDTH  = rf2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rf2d_pkg::MAX_HEIGHT_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  rf2d_pkg::cfg_t                       cfg,
  input  rf2d_pkg::cmd_t                       cmd,
  output rf2d_pkg::status_t                    status,
  input  wire signed [rf2d_pkg::SMP_W-1:0]     in_sample,
  input  wire                                  out_ready,
  output logic                                 out_valid,
  output logic signed [rf2d_pkg::VAL_W-1:0]    out_filtered_value,
  output logic                                 out_end_of_row,
  output logic                                 out_end_of_frame,
  output logic                                 out_saturated
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WEW = ($clog2(MAX_WIDTH + 1) > rf2d_pkg::DIM_W) ?
                       $clog2(MAX_WIDTH + 1) : rf2d_pkg::DIM_W;
  localparam int HEW = ($clog2(MAX_HEIGHT + 1) > rf2d_pkg::DIM_W) ?
                       $clog2(MAX_HEIGHT + 1) : rf2d_pkg::DIM_W;

  function automatic logic signed [34:0] rnd_q14(input logic signed [47:0] p);
    logic signed [48:0] t;
    t = {p[47], p} + 49'sd8192;
    return t[48:14];
  endfunction

  function automatic logic ovf32(input logic signed [35:0] s);
    return (s > 36'sd2147483647) || (s < -36'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [35:0] s);
    logic signed [31:0] r;
    if (s > 36'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (s < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // line store
  logic signed [31:0] line_mem [MAX_WIDTH];
  logic signed [31:0] rd_r;

  // position and frame size
  logic [CW-1:0]  col_r, col_nxt, col_eff, cur_col_r;
  logic [RW-1:0]  row_r, row_nxt, row_eff;
  logic [WEW-1:0] w_ext, w_eff;
  logic [HEW-1:0] h_ext, h_eff;
  logic           eor, eof;
  logic           eor_r, eof_r, fb_row_en_r, fb_col_en_r;

  // arithmetic
  logic signed [15:0] x_r;
  logic signed [31:0] pa_r;
  logic signed [47:0] pb_r, qa_r, qb_r;
  logic signed [34:0] rnd_pa, rnd_pb, rnd_qa, rnd_qb;
  logic signed [35:0] s1, s2;
  logic signed [31:0] v_r, y_r, carry_r, v_nxt, y_nxt;
  logic               sat_r;

  logic out_valid_r, out_valid_nxt;

  assign w_ext = WEW'(cfg.width);
  assign h_ext = HEW'(cfg.height);

  always_comb begin
    priority if (w_ext == '0) begin
      w_eff = WEW'(1);
    end else if (w_ext > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    priority if (h_ext == '0) begin
      h_eff = HEW'(1);
    end else if (h_ext > HEW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  assign col_eff = (WEW'(col_r) >= w_eff) ? '0 : col_r;
  assign row_eff = (HEW'(row_r) >= h_eff) ? '0 : row_r;
  assign eor     = (WEW'(col_eff) == (w_eff - WEW'(1)));
  assign eof     = eor && (HEW'(row_eff) == (h_eff - HEW'(1)));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.accept) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = eof ? '0 : (row_eff + RW'(1));
      end else begin
        col_nxt = col_eff + CW'(1);
        row_nxt = row_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      carry_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (cmd.sum2) begin
        carry_r <= y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_r <= line_mem[col_eff];
    end
    if (cmd.sum1) begin
      line_mem[cur_col_r] <= v_nxt;
    end
  end

  assign rnd_pa = rnd_q14({{16{pa_r[31]}}, pa_r});
  assign rnd_pb = rnd_q14(pb_r);
  assign rnd_qa = rnd_q14(qa_r);
  assign rnd_qb = rnd_q14(qb_r);
  assign s1 = {rnd_pa[34], rnd_pa} + {rnd_pb[34], rnd_pb};
  assign s2 = {rnd_qa[34], rnd_qa} + {rnd_qb[34], rnd_qb};
  assign v_nxt = clip32(s1);
  assign y_nxt = clip32(s2);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r         <= in_sample;
      cur_col_r   <= col_eff;
      fb_row_en_r <= (row_eff != '0);
      fb_col_en_r <= (col_eff != '0);
      eor_r       <= eor;
      eof_r       <= eof;
    end
    if (cmd.mul1) begin
      pa_r <= cfg.ff * x_r;
      pb_r <= fb_row_en_r ? (cfg.fb * rd_r) : 48'sd0;
    end
    if (cmd.sum1) begin
      v_r   <= v_nxt;
      sat_r <= ovf32(s1);
    end
    if (cmd.mul2) begin
      qa_r <= cfg.ff * v_r;
      qb_r <= fb_col_en_r ? (cfg.fb * carry_r) : 48'sd0;
    end
    if (cmd.sum2) begin
      y_r   <= y_nxt;
      sat_r <= sat_r | ovf32(s2);
    end
    if (cmd.load_out) begin
      out_filtered_value <= y_r;
      out_end_of_row     <= eor_r;
      out_end_of_frame   <= eof_r;
      out_saturated      <= sat_r;
    end
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// File: sv/recursive_filter_2d_down_right.sv
// two-pass first-order recursive image filter, column pass then row pass
// a new request is accepted only in idle, after the previous result has been
// computed by the multiply/sum sequence and handed to the output register
// reset (synchronous, active low) returns position to row 0 column 0, clears
// the row carry and output valid, and restores register defaults; the line
// store is not cleared
`default_nettype none

module recursive_filter_2d_down_right #(
  parameter int MAX_WIDTH  = rf2d_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rf2d_pkg::MAX_HEIGHT_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [rf2d_pkg::ADDR_W-1:0]          paddr,
  input  wire  [rf2d_pkg::DATA_W-1:0]          pwdata,
  output logic [rf2d_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire signed [rf2d_pkg::SMP_W-1:0]     in_sample,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic signed [rf2d_pkg::VAL_W-1:0]    out_filtered_value,
  output logic                                 out_end_of_row,
  output logic                                 out_end_of_frame,
  output logic                                 out_saturated
);

  rf2d_pkg::cfg_t    cfg;
  rf2d_pkg::cmd_t    cmd;
  rf2d_pkg::status_t status;

  rf2d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rf2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rf2d_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .status             (status),
    .in_sample          (in_sample),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_filtered_value (out_filtered_value),
    .out_end_of_row     (out_end_of_row),
    .out_end_of_frame   (out_end_of_frame),
    .out_saturated      (out_saturated)
  );

endmodule

`default_nettype wire
